// ----- rtl/pct_pkg.sv -----
// Shared types and constants for the path constraint table.
`default_nettype none
package pct_pkg;

  localparam int unsigned MAX_INTERVALS_DEF = 64;
  localparam int unsigned MAX_LANDMARKS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF     = 16;

  localparam logic [15:0] VERTEX_COUNT_RST = 16'd1024;

  typedef enum logic [1:0] {
    FUNC_INS_INTERVAL = 2'd0,
    FUNC_INS_LANDMARK = 2'd1,
    FUNC_Q_CONSTR     = 2'd2,
    FUNC_Q_HOLD       = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_CLASH = 2'd2
  } status_e;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_MIN_PATH     = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] location;
    logic [15:0] time_start;
    logic [15:0] time_end;
  } in_word_t;

  typedef struct packed {
    logic        is_constrained;
    logic [15:0] holding_time;
    logic [15:0] latest_time;
    logic [1:0]  status;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture input word, clear flags, preset hold time
    logic scan_lm;   // evaluate landmark entry at scan index
    logic scan_iv;   // evaluate interval entry at scan index
    logic step;      // advance scan index
    logic rst_idx;   // restart scan index
    logic commit;    // perform the write / finish the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic       lm_last;  // index at last valid landmark or none left
    logic       iv_last;
    logic       lm_none;
    logic       iv_none;
    logic [1:0] func;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/pct_datapath.sv -----
// Datapath: constraint stores, scan index and result accumulation.
`default_nettype none
module pct_datapath #(
  parameter int unsigned MaxIntervals = 64,
  parameter int unsigned MaxLandmarks = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire pct_pkg::cmd_t   cmd_i,
  output pct_pkg::sts_t        sts_o,
  input  wire pct_pkg::in_word_t in_i,
  input  wire [15:0]           vertex_count_i,
  input  wire [15:0]           min_path_i,
  output pct_pkg::out_word_t   res_o
);
  import pct_pkg::*;

  localparam int unsigned TimeBits = TIME_BITS_DEF;
  localparam int unsigned IvW  = (MaxIntervals > 1) ? $clog2(MaxIntervals) : 1;
  localparam int unsigned LmW  = (MaxLandmarks > 1) ? $clog2(MaxLandmarks) : 1;
  localparam int unsigned IdxW = (IvW > LmW) ? IvW : LmW;
  localparam int unsigned IvCW = $clog2(MaxIntervals + 1);
  localparam int unsigned LmCW = $clog2(MaxLandmarks + 1);
  localparam logic [TimeBits-1:0] MaxTime = {TimeBits{1'b1}};

  logic [15:0]         iv_loc_mem [MaxIntervals];
  logic [TimeBits-1:0] iv_st_mem  [MaxIntervals];
  logic [TimeBits-1:0] iv_en_mem  [MaxIntervals];
  logic [15:0]         lm_loc_mem [MaxLandmarks];
  logic [TimeBits-1:0] lm_tm_mem  [MaxLandmarks];

  logic [IvCW-1:0]     iv_cnt_q;
  logic [LmCW-1:0]     lm_cnt_q;
  logic [TimeBits-1:0] latest_q;
  logic [IdxW-1:0]     idx_q, idx_d;

  logic [1:0]          func_q;
  logic [15:0]         loc_q;
  logic [TimeBits-1:0] ts_q, te_q;
  logic                con_q, found_q, clash_q;
  logic [TimeBits-1:0] hold_q;
  out_word_t           res_q;

  logic [15:0]         rd_iv_loc_q, rd_lm_loc_q;
  logic [TimeBits-1:0] rd_iv_st_q, rd_iv_en_q, rd_lm_tm_q, lm_inc;
  logic [IdxW:0]       idx_nx;

  logic [TimeBits-1:0] latest_nx;
  status_e             status_nx;
  logic                iv_wr, lm_wr;

  // Next scan index; the stores are read at it so read data lines up with idx_q
  assign idx_nx    = {1'b0, idx_q} + 1'b1;
  assign idx_d     = cmd_i.rst_idx ? '0 : (cmd_i.step ? idx_nx[IdxW-1:0] : idx_q);
  assign lm_inc    = (rd_lm_tm_q == MaxTime) ? MaxTime : rd_lm_tm_q + 1'b1;

  assign sts_o.lm_none = (lm_cnt_q == '0);
  assign sts_o.iv_none = (iv_cnt_q == '0);
  assign sts_o.lm_last = (idx_nx >= (IdxW+1)'(lm_cnt_q));
  assign sts_o.iv_last = (idx_nx >= (IdxW+1)'(iv_cnt_q));
  assign sts_o.func    = func_q;

  // Work out the latest step, the status and the store writes of a commit
  always_comb begin
    latest_nx = latest_q;
    status_nx = ST_OK;
    iv_wr     = 1'b0;
    lm_wr     = 1'b0;
    case (func_q)
      FUNC_INS_INTERVAL: begin
        if (iv_cnt_q < IvCW'(MaxIntervals)) begin
          iv_wr = 1'b1;
          if (te_q != MaxTime && te_q > latest_q) latest_nx = te_q;
          else if (te_q == MaxTime && ts_q > latest_q) latest_nx = ts_q;
        end else begin
          status_nx = ST_FULL;
        end
      end
      FUNC_INS_LANDMARK: begin
        if (found_q) begin
          status_nx = clash_q ? ST_CLASH : ST_OK;
        end else if (lm_cnt_q < LmCW'(MaxLandmarks)) begin
          lm_wr = 1'b1;
          if (ts_q > latest_q) latest_nx = ts_q;
        end else begin
          status_nx = ST_FULL;
        end
      end
      default: ;
    endcase
  end

  // Write stores on commit of an insert; read them at the next scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && iv_wr) begin
      iv_loc_mem[iv_cnt_q[IvW-1:0]] <= loc_q;
      iv_st_mem[iv_cnt_q[IvW-1:0]]  <= ts_q;
      iv_en_mem[iv_cnt_q[IvW-1:0]]  <= te_q;
    end
    if (cmd_i.commit && lm_wr) begin
      lm_loc_mem[lm_cnt_q[LmW-1:0]] <= loc_q;
      lm_tm_mem[lm_cnt_q[LmW-1:0]]  <= ts_q;
    end
    rd_iv_loc_q <= iv_loc_mem[idx_d[IvW-1:0]];
    rd_iv_st_q  <= iv_st_mem[idx_d[IvW-1:0]];
    rd_iv_en_q  <= iv_en_mem[idx_d[IvW-1:0]];
    rd_lm_loc_q <= lm_loc_mem[idx_d[LmW-1:0]];
    rd_lm_tm_q  <= lm_tm_mem[idx_d[LmW-1:0]];
  end

  // Control-side registers: counts, latest step, index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_cnt_q <= '0;
      lm_cnt_q <= '0;
      latest_q <= '0;
      idx_q    <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.commit) begin
        latest_q <= latest_nx;
        if (iv_wr) iv_cnt_q <= iv_cnt_q + 1'b1;
        if (lm_wr) lm_cnt_q <= lm_cnt_q + 1'b1;
      end
    end
  end

  // Capture the word and accumulate over the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= in_i.func;
      loc_q   <= in_i.location;
      ts_q    <= in_i.time_start[TimeBits-1:0];
      te_q    <= in_i.time_end[TimeBits-1:0];
      con_q   <= 1'b0;
      found_q <= 1'b0;
      clash_q <= 1'b0;
      hold_q  <= min_path_i[TimeBits-1:0];
    end else begin
      if (cmd_i.scan_lm) begin
        if (func_q == FUNC_INS_LANDMARK && !found_q && rd_lm_tm_q == ts_q) begin
          found_q <= 1'b1;
          clash_q <= (rd_lm_loc_q != loc_q);
        end
        if (func_q == FUNC_Q_CONSTR && loc_q < vertex_count_i &&
            rd_lm_tm_q == ts_q && rd_lm_loc_q != loc_q)
          con_q <= 1'b1;
        if (func_q == FUNC_Q_HOLD && rd_lm_loc_q != loc_q && lm_inc > hold_q)
          hold_q <= lm_inc;
      end
      if (cmd_i.scan_iv) begin
        if (func_q == FUNC_Q_CONSTR && rd_iv_loc_q == loc_q && rd_iv_st_q <= ts_q &&
            (rd_iv_en_q == MaxTime || ts_q < rd_iv_en_q))
          con_q <= 1'b1;
        if (func_q == FUNC_Q_HOLD && rd_iv_loc_q == loc_q && rd_iv_en_q > hold_q)
          hold_q <= rd_iv_en_q;
      end
    end
  end

  // Register the result word on commit, with the latest step after the commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q.is_constrained <= (func_q == FUNC_Q_CONSTR) ? con_q : 1'b0;
      res_q.holding_time   <= (func_q == FUNC_Q_HOLD) ? 16'(hold_q) : 16'd0;
      res_q.latest_time    <= 16'(latest_nx);
      res_q.status         <= status_nx;
    end
  end

  assign res_o = res_q;

  // Counts never exceed their store depths; the latest step moves only on commit
  a_iv_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iv_cnt_q <= IvCW'(MaxIntervals)) else $error("interval count overflow");
  a_lm_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lm_cnt_q <= LmCW'(MaxLandmarks)) else $error("landmark count overflow");
  a_latest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> latest_q == $past(latest_q)) else $error("latest step moved");
endmodule
`default_nettype wire

// ----- rtl/pct_ctrl.sv -----
// Controller: sequences load, landmark scan, interval scan, commit, output.
`default_nettype none
module pct_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  input  wire pct_pkg::sts_t sts_i,
  output pct_pkg::cmd_t   cmd_o
);
  import pct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN_LM, S_SCAN_IV, S_COMMIT, S_LATCH
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   in_acc;

  // Accept a new word only when idle and the output slot is free or leaving
  assign in_stall_o  = (state_q != S_IDLE) || (ov_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_o.load    = 1'b1;
          cmd_o.rst_idx = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.rst_idx = 1'b1;
        if (sts_i.func == FUNC_INS_INTERVAL) state_d = S_COMMIT;
        else if (!sts_i.lm_none && sts_i.func != FUNC_INS_INTERVAL) state_d = S_SCAN_LM;
        else if (sts_i.func == FUNC_INS_LANDMARK) state_d = S_COMMIT;
        else if (!sts_i.iv_none) state_d = S_SCAN_IV;
        else state_d = S_COMMIT;
      end
      S_SCAN_LM: begin
        cmd_o.scan_lm = 1'b1;
        cmd_o.step    = 1'b1;
        if (sts_i.lm_last) begin
          cmd_o.rst_idx = 1'b1;
          if (sts_i.func == FUNC_INS_LANDMARK || sts_i.iv_none) state_d = S_COMMIT;
          else state_d = S_SCAN_IV;
        end
      end
      S_SCAN_IV: begin
        cmd_o.scan_iv = 1'b1;
        cmd_o.step    = 1'b1;
        if (sts_i.iv_last) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_LATCH;
      end
      S_LATCH: begin
        if (!ov_d) begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.scan_lm, cmd_o.scan_iv, cmd_o.commit}))
    else $error("conflicting commands");
  a_acc_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_DECODE) else $error("accept without decode");
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !out_valid_o)
    else $error("result overwritten");
endmodule
`default_nettype wire

// ----- rtl/path_constraint_table.sv -----
// Top level of the path constraint table.
//
//  port group   | direction | handshake        | payload
//  in_*         | in        | valid / stall    | pct_pkg::in_word_t
//  out_*        | out       | valid / stall    | pct_pkg::out_word_t
//  cfg_*        | in        | valid / ready    | index, data
//
// A query scans every stored landmark and then every stored interval,
// one entry per cycle; interval inserts skip both scans and landmark
// inserts scan the landmarks only.
// Reset is asynchronous and empties all stores at once via their counts.
// A result waits in the output register while out_stall_i is high; the
// next word is only accepted once its result is being handed on.
`default_nettype none
module path_constraint_table #(
  parameter int unsigned MaxIntervals = pct_pkg::MAX_INTERVALS_DEF,
  parameter int unsigned MaxLandmarks = pct_pkg::MAX_LANDMARKS_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wire pct_pkg::in_word_t in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output pct_pkg::out_word_t     out_data_o,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire                    cfg_index_i,
  input  wire [15:0]             cfg_data_i
);
  import pct_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [15:0] vcount_q, minpath_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= VERTEX_COUNT_RST;
      minpath_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_VERTEX_COUNT) vcount_q <= cfg_data_i;
      if (cfg_index_i == CFG_MIN_PATH)     minpath_q <= cfg_data_i;
    end
  end

  pct_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  pct_datapath #(
    .MaxIntervals(MaxIntervals), .MaxLandmarks(MaxLandmarks)
  ) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .in_i(in_data_i),
    .vertex_count_i(vcount_q), .min_path_i(minpath_q), .res_o(out_data_o)
  );
endmodule
`default_nettype wire
